FILE: design/modular_exponentiation_core_macros.svh
// Assertion macros shared by the modular exponentiation RTL.
// Used by files that check their own control logic; needs clk and rst in scope.
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MEXP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("modexp assertion failed");

// Next-cycle implication, disabled during reset.
`define MEXP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("modexp assertion failed");

`endif

FILE: design/mexp_pkg.sv
// Package for the modular exponentiation core: widths, register indexes,
// the ring slot type and the modular add helper. No dependencies.
package mexp_pkg;

  localparam int KEY_WIDTH = 64;
  localparam int PASS_LAST = 2 * KEY_WIDTH;
  localparam int PASS_W    = $clog2(PASS_LAST + 1);
  localparam int IDX_W     = $clog2(KEY_WIDTH);
  localparam int IO_W      = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

  localparam logic [KEY_WIDTH-1:0] EXPONENT_RESET = KEY_WIDTH'(65537);
  localparam logic [KEY_WIDTH-1:0] MODULUS_RESET  = KEY_WIDTH'(3);

  typedef logic [KEY_WIDTH-1:0] word_t;

  // One item in flight: the pass it is in and the operands of that pass.
  typedef struct packed {
    logic              valid;
    logic [PASS_W-1:0] pass;
    word_t             base;
    word_t             a;
    word_t             b;
    word_t             acc;
  } mexp_slot_t;

  // (x + y) mod m for x and y both below m.
  function automatic word_t add_mod(word_t x, word_t y, word_t m);
    word_t room;
    room = m - y;
    if (x >= room) begin
      return x - room;
    end
    return x + y;
  endfunction

endpackage

FILE: design/mexp_cell.sv
// One cell of the multiplier ring: a single double-and-add step of a*b mod m.
// Depends on mexp_pkg.
module mexp_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  mexp_pkg::word_t     modulus,
  input  mexp_pkg::mexp_slot_t slot_in,
  output mexp_pkg::mexp_slot_t slot_out
);
  import mexp_pkg::*;

  mexp_slot_t slot_next;
  word_t      dbl;

  // Double the accumulator, add a when the top bit of b is set, then shift b.
  always_comb begin
    slot_next = slot_in;
    dbl = add_mod(slot_in.acc, slot_in.acc, modulus);
    if (slot_in.b[KEY_WIDTH-1]) begin
      slot_next.acc = add_mod(dbl, slot_in.a, modulus);
    end else begin
      slot_next.acc = dbl;
    end
    slot_next.b = {slot_in.b[KEY_WIDTH-2:0], 1'b0};
  end

  // Payload needs no reset; only the valid flag is cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_out.valid <= 1'b0;
    end else if (en) begin
      slot_out <= slot_next;
    end
  end

endmodule

FILE: design/modular_exponentiation_core.sv
// Modular exponentiation core: a ring of KEY_WIDTH cells, each taking one
// double-and-add step, so a full modular multiply is one trip round the ring.
// An item makes 2*KEY_WIDTH+1 trips: one to reduce the base modulo the
// modulus, then a square and a multiply per exponent bit. The ring holds
// KEY_WIDTH items at once, one per cell, so it takes new items before earlier
// ones finish; it stalls while a finished item cannot leave. Results leave in
// input order. A modulus below 2 yields 0. Configuration writes are taken at
// any time but must be made idle.
// Depends on mexp_pkg, mexp_cell and modular_exponentiation_core_macros.svh.
`include "modular_exponentiation_core_macros.svh"

module modular_exponentiation_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mexp_pkg::IO_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mexp_pkg::IO_W-1:0]            base_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mexp_pkg::IO_W-1:0]            power_result
);
  import mexp_pkg::*;

  word_t             exponent;
  word_t             modulus;
  mexp_slot_t        chain [KEY_WIDTH];
  mexp_slot_t        entry;
  mexp_slot_t        exit_slot;
  logic              done;
  logic              en;
  logic              ebit;
  logic [IDX_W-1:0]  bitpos;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= EXPONENT_RESET;
      modulus  <= MODULUS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXPONENT: exponent <= cfg_data[KEY_WIDTH-1:0];
        REG_MODULUS:  modulus  <= cfg_data[KEY_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The ring stalls as a whole only when a finished item cannot leave.
  assign exit_slot = chain[KEY_WIDTH-1];
  assign done      = exit_slot.valid && (exit_slot.pass == PASS_W'(PASS_LAST));
  assign en        = !(done && out_valid && !out_ready);
  assign in_ready  = en && (!exit_slot.valid || done);

  // Exponent bit for the multiply pass that follows the current pass.
  assign bitpos = IDX_W'(KEY_WIDTH - 1) - exit_slot.pass[IDX_W:1];
  assign ebit   = exponent[bitpos];

  // Set up the next pass of the slot wrapping round, or load a new item.
  always_comb begin
    entry     = exit_slot;
    entry.acc = '0;
    if (!exit_slot.valid || done) begin
      entry.valid = in_valid;
      entry.pass  = '0;
      entry.base  = '0;
      entry.a     = KEY_WIDTH'(1);
      entry.b     = base_value[KEY_WIDTH-1:0];
    end else begin
      entry.pass = exit_slot.pass + PASS_W'(1);
      if (exit_slot.pass == '0) begin
        // Base reduced; start the power at 1 with a square of 1.
        entry.base = exit_slot.acc;
        entry.a    = KEY_WIDTH'(1);
        entry.b    = KEY_WIDTH'(1);
      end else if (!exit_slot.pass[0]) begin
        // Square pass.
        entry.a = exit_slot.acc;
        entry.b = exit_slot.acc;
      end else begin
        // Multiply pass, by the base or by one.
        entry.a = exit_slot.acc;
        entry.b = ebit ? exit_slot.base : KEY_WIDTH'(1);
      end
    end
  end

  // The ring of cells.
  for (genvar k = 0; k < KEY_WIDTH; k++) begin : g_cell
    mexp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .modulus  (modulus),
      .slot_in  ((k == 0) ? entry : chain[(k == 0) ? 0 : k - 1]),
      .slot_out (chain[k])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && en) begin
      power_result <= (modulus < KEY_WIDTH'(2)) ? '0 : IO_W'(exit_slot.acc);
    end
  end

  // An item is taken only into a free slot or one that is leaving.
  `MEXP_ASSERT_NOW(a_take_free_slot, in_ready, !exit_slot.valid || done)
  // A stalled ring keeps its finished item at the exit.
  `MEXP_ASSERT_NEXT(a_stall_holds, !en, done)
  // A finished item always reaches the output register.
  `MEXP_ASSERT_NEXT(a_done_shown, done && en, out_valid)
  // A degenerate modulus gives a zero result.
  `MEXP_ASSERT_NEXT(a_small_modulus, done && en && (modulus < KEY_WIDTH'(2)),
                    power_result == '0)

endmodule
